// ----- rtl/core/multicycle_cpu_control_fsm_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the multicycle CPU control sequencer.
// Each macro expands to one labelled concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef MULTICYCLE_CPU_CONTROL_FSM_ASSERT_SVH
`define MULTICYCLE_CPU_CONTROL_FSM_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define MCCF_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next, outside reset.
`define MCCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle, checked through reset too.
`define MCCF_ASSERT_NEXT_RAW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/mccf_pkg.sv -----
// ---------------------------------------------------------------------------
// mccf_pkg
// Types and constants shared by the multicycle CPU control sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package mccf_pkg;

  localparam int OPCODE_W = 5;
  localparam int ADDR_W   = 9;

  // Opcodes decoded in the dispatch phase.
  localparam logic [OPCODE_W-1:0] OP_HALT  = 5'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 5'd8;
  localparam logic [OPCODE_W-1:0] OP_STORE = 5'd9;
  localparam logic [OPCODE_W-1:0] OP_JUMP  = 5'd10;
  localparam logic [OPCODE_W-1:0] OP_JNEG  = 5'd11;
  localparam logic [OPCODE_W-1:0] OP_JZERO = 5'd12;

  // Bit positions inside each two-bit unit control field.
  localparam int CTL_EN = 0;
  localparam int CTL_WR = 1;

  typedef enum logic [3:0] {
    PH_FETCH      = 4'd0,
    PH_LOAD_IR    = 4'd1,
    PH_PIPE       = 4'd2,
    PH_NEXT       = 4'd3,
    PH_DISPATCH   = 4'd4,
    PH_EXEC_ALU   = 4'd5,
    PH_EXEC_STORE = 4'd6,
    PH_EXEC_JUMP  = 4'd7,
    PH_WRITEBACK  = 4'd8,
    PH_EXEC_LOAD  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                neg_flag;
    logic                zero_flag;
    logic [ADDR_W-1:0]   jump_address;
  } in_word_t;

  typedef struct packed {
    logic              pc_enable;
    logic              pc_load;
    logic [ADDR_W-1:0] jump_target;
    logic [1:0]        imem_ctl;
    logic [1:0]        ir_ctl;
    logic [1:0]        regbank_ctl;
    logic [1:0]        pipe_ctl;
    logic [1:0]        datamem_ctl;
    logic              clear_flags;
    logic              read_select;
    logic              write_select;
    logic              halted;
  } out_word_t;

  // Handshake between the input stage and the sequencer.
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/mccf_in_stage.sv -----
// ---------------------------------------------------------------------------
// mccf_in_stage
// Input register: holds one accepted tick word until the sequencer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mccf_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mccf_pkg::in_word_t in_data,
  output mccf_pkg::item_t        item,
  input  wire logic              take
);
  import mccf_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  in_word_t word_r;

  // A new word may enter when the register is empty or is being emptied now.
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_data;
    end
  end

  assign item.valid = vld_r;
  assign item.word  = word_r;

endmodule

`default_nettype wire

// ----- rtl/core/mccf_seq.sv -----
// ---------------------------------------------------------------------------
// mccf_seq
// Ten-phase control sequencer with held strobes; the strobe register is
// also the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mccf_seq #(
  parameter logic [mccf_pkg::OPCODE_W-1:0] OP_MASK   = 5'h1F,
  parameter logic [mccf_pkg::ADDR_W-1:0]   ADDR_MASK = 9'h1FF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mccf_pkg::item_t    item,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mccf_pkg::out_word_t     out_data
);
  import mccf_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic                restart_r, restart_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_r, out_nxt;
  logic [OPCODE_W-1:0] op;
  logic                taken;

  // The state only moves when the result register can take the new word.
  assign take = item.valid && (!out_valid_r || out_ready);
  assign op   = item.word.opcode & OP_MASK;

  always_comb begin
    phase_nxt   = phase_r;
    restart_nxt = restart_r;
    out_nxt     = out_r;
    taken       = 1'b0;
    if (!out_r.halted) begin
      unique case (phase_r)
        PH_FETCH: begin
          out_nxt.pc_enable        = 1'b1;
          out_nxt.imem_ctl[CTL_EN] = 1'b1;
          out_nxt.imem_ctl[CTL_WR] = 1'b0;
          phase_nxt                = PH_LOAD_IR;
        end
        PH_LOAD_IR: begin
          out_nxt.pc_enable        = 1'b0;
          out_nxt.imem_ctl[CTL_EN] = 1'b0;
          out_nxt.ir_ctl           = 2'b11;
          phase_nxt                = PH_PIPE;
        end
        PH_PIPE: begin
          if (restart_r) begin
            restart_nxt = 1'b0;
            phase_nxt   = PH_FETCH;
          end else begin
            out_nxt.ir_ctl[CTL_EN] = 1'b0;
            out_nxt.pipe_ctl       = 2'b11;
            phase_nxt              = PH_NEXT;
          end
        end
        PH_NEXT: begin
          out_nxt.pipe_ctl[CTL_EN] = 1'b0;
          out_nxt.pc_enable        = 1'b1;
          out_nxt.imem_ctl[CTL_EN] = 1'b1;
          out_nxt.imem_ctl[CTL_WR] = 1'b0;
          phase_nxt                = PH_DISPATCH;
        end
        PH_DISPATCH: begin
          out_nxt.pc_enable        = 1'b0;
          out_nxt.imem_ctl[CTL_EN] = 1'b0;
          out_nxt.ir_ctl           = 2'b11;
          unique case (op)
            OP_LOAD: begin
              out_nxt.read_select      = 1'b1;
              out_nxt.write_select     = 1'b1;
              out_nxt.regbank_ctl      = 2'b11;
              out_nxt.datamem_ctl[CTL_EN] = 1'b1;
              out_nxt.datamem_ctl[CTL_WR] = 1'b0;
              phase_nxt                = PH_EXEC_LOAD;
            end
            OP_STORE: begin
              out_nxt.regbank_ctl  = 2'b01;
              out_nxt.write_select = 1'b0;
              phase_nxt            = PH_EXEC_STORE;
            end
            OP_JUMP: begin
              taken     = 1'b1;
              phase_nxt = PH_EXEC_JUMP;
            end
            OP_JNEG: begin
              taken     = item.word.neg_flag;
              phase_nxt = PH_EXEC_JUMP;
            end
            OP_JZERO: begin
              taken     = item.word.zero_flag;
              phase_nxt = PH_EXEC_JUMP;
            end
            OP_HALT: begin
              out_nxt.halted = 1'b1;
            end
            default: begin
              out_nxt.read_select = 1'b0;
              out_nxt.regbank_ctl = 2'b01;
              phase_nxt           = PH_EXEC_ALU;
            end
          endcase
          if (taken) begin
            out_nxt.jump_target = item.word.jump_address & ADDR_MASK;
            out_nxt.pc_enable   = 1'b0;
            out_nxt.pc_load     = 1'b1;
            restart_nxt         = 1'b1;
            // Only the conditional jumps clear the ALU flags.
            if (op != OP_JUMP) begin
              out_nxt.clear_flags = 1'b1;
            end
          end
        end
        PH_EXEC_ALU: begin
          out_nxt.regbank_ctl    = 2'b11;
          out_nxt.ir_ctl[CTL_EN] = 1'b0;
          phase_nxt              = PH_WRITEBACK;
        end
        PH_EXEC_STORE: begin
          out_nxt.datamem_ctl    = 2'b11;
          out_nxt.ir_ctl[CTL_EN] = 1'b0;
          phase_nxt              = PH_WRITEBACK;
        end
        PH_EXEC_JUMP: begin
          out_nxt.pc_load     = 1'b0;
          out_nxt.clear_flags = 1'b0;
          phase_nxt           = PH_PIPE;
        end
        PH_WRITEBACK: begin
          out_nxt.regbank_ctl[CTL_EN] = 1'b0;
          out_nxt.datamem_ctl[CTL_EN] = 1'b0;
          out_nxt.ir_ctl[CTL_EN]      = 1'b0;
          phase_nxt                   = PH_PIPE;
        end
        PH_EXEC_LOAD: begin
          out_nxt.regbank_ctl = 2'b11;
          phase_nxt           = PH_WRITEBACK;
        end
        default: begin
          phase_nxt = PH_FETCH;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FETCH;
      restart_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r   <= phase_nxt;
        restart_r <= restart_nxt;
        out_r     <= out_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/multicycle_cpu_control_fsm.sv -----
// Path: a word goes through the input register, then the strobe register, to the output.
// Throughput: one word per cycle while out_ready holds; the input register and the
// strobe register each take a new word in the cycle the previous one moves on.
// Reset: synchronous, active low; phase returns to fetch, every strobe,
// the jump target and the halt flag clear, and both registers empty.
// ---------------------------------------------------------------------------
// multicycle_cpu_control_fsm
// Top level of the control sequencer for a small multicycle processor.
// ---------------------------------------------------------------------------
`default_nettype none

module multicycle_cpu_control_fsm #(
  parameter int ADDR_BITS   = 9,
  parameter int OPCODE_BITS = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mccf_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mccf_pkg::out_word_t      out_data
);
  import mccf_pkg::*;

  // Opcode and target are reduced to the configured widths.
  localparam logic [OPCODE_W-1:0] OP_MASK = (OPCODE_BITS >= OPCODE_W) ?
      {OPCODE_W{1'b1}} : OPCODE_W'((1 << OPCODE_BITS) - 1);
  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ?
      {ADDR_W{1'b1}} : ADDR_W'((1 << ADDR_BITS) - 1);

  item_t item;
  logic  take;

  mccf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .item     (item),
    .take     (take)
  );

  mccf_seq #(
    .OP_MASK   (OP_MASK),
    .ADDR_MASK (ADDR_MASK)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/mccf_checker.sv -----
// ---------------------------------------------------------------------------
// mccf_checker
// Port-level checks on the control sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "multicycle_cpu_control_fsm_assert.svh"

module mccf_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire mccf_pkg::in_word_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mccf_pkg::out_word_t out_data
);
  import mccf_pkg::*;

  // A waiting input word must hold still until it is taken.
  `MCCF_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
    in_valid && $stable(in_data), "input word changed while waiting")

  // A stalled result word must hold still.
  `MCCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_data), "result word changed while stalled")

  // Once halted, the machine stays halted until reset.
  `MCCF_ASSERT_NEXT(a_halt_sticky, clk, rst_n, out_data.halted,
    out_data.halted, "halted flag dropped without reset")

  // A jump load never coincides with a program counter increment, and the
  // flag clear only ever accompanies a jump load.
  `MCCF_ASSERT_ALWAYS(a_pc_excl, clk, rst_n,
    !(out_data.pc_enable && out_data.pc_load) &&
    (!out_data.clear_flags || out_data.pc_load), "conflicting program counter strobes")

  // Nothing is presented in the cycle after reset.
  `MCCF_ASSERT_NEXT_RAW(a_reset_empty, clk, !rst_n, !out_valid,
    "result valid directly after reset")

endmodule

bind multicycle_cpu_control_fsm mccf_checker u_mccf_checker (.*);

`default_nettype wire
